@@ sv/hswt_pkg.sv @@
// ----------------------------------------------------------------------------
// hswt_pkg - shared types for the tagged heap sorter
// State encodings for the top-level sequencer and the heapsort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hswt_pkg;

   // top-level phases: collect a set, sort it in place, stream it out
   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } top_state_type;

   // heapsort engine steps, at most one memory access per step
   typedef enum logic [8:0] {
      SS_IDLE      = 9'b000000001,
      SS_OUTER     = 9'b000000010,
      SS_LOAD_HK   = 9'b000000100,
      SS_TAKE_LAST = 9'b000001000,
      SS_ROOT_RD   = 9'b000010000,
      SS_FINAL_WR  = 9'b000100000,
      SS_SIFT      = 9'b001000000,
      SS_RD_A      = 9'b010000000,
      SS_RD_B      = 9'b100000000
   } sort_state_type;

endpackage : hswt_pkg

`default_nettype wire

@@ sv/hswt_sorter.sv @@
// ----------------------------------------------------------------------------
// hswt_sorter - in-place heapsort engine
// Drives one write port and one registered read port of the item memory.
// Builds a max-heap, then moves the root to the end and sifts down.
// ----------------------------------------------------------------------------
`default_nettype none

module hswt_sorter #(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_BITS  = 32,
   parameter int TAG_BITS  = 16,
   parameter int IW        = $clog2(MAX_ITEMS + 1),
   parameter int AW        = $clog2(MAX_ITEMS),
   parameter int DW        = KEY_BITS + TAG_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          sort_start,
   input  wire logic [IW-1:0] item_num,
   output logic               sort_done,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output logic [DW-1:0]      mem_wdata,
   output logic [AW-1:0]      mem_raddr,
   input  wire logic [DW-1:0] mem_rd_data
);
   import hswt_pkg::*;

   sort_state_type st_ff, st_in;
   logic [IW-1:0]  lo_ff, lo_in;
   logic [IW-1:0]  hi_ff, hi_in;
   logic [IW-1:0]  pos_ff, pos_in;
   logic [IW:0]    kid_ff, kid_in;
   logic [DW-1:0]  hk_ff, hk_in;
   logic [DW-1:0]  a_ff, a_in;

   logic [IW-1:0]  pos_m1;
   logic [IW-1:0]  hi_m1;
   logic [IW:0]    kid_m1;
   logic [DW-1:0]  big_word;
   logic [IW-1:0]  big_idx;

   assign pos_m1 = pos_ff - IW'(1);
   assign hi_m1  = hi_ff - IW'(1);
   assign kid_m1 = kid_ff - (IW+1)'(1);

   // larger of the two children; on a tie the left child wins
   always_comb begin
      if ($signed(a_ff[DW-1:TAG_BITS]) < $signed(mem_rd_data[DW-1:TAG_BITS])) begin
         big_word = mem_rd_data;
         big_idx  = kid_ff[IW-1:0] + IW'(1);
      end else begin
         big_word = a_ff;
         big_idx  = kid_ff[IW-1:0];
      end
   end

   always_comb begin
      st_in     = st_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      pos_in    = pos_ff;
      kid_in    = kid_ff;
      hk_in     = hk_ff;
      a_in      = a_ff;
      sort_done = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = pos_m1[AW-1:0];
      mem_wdata = hk_ff;
      mem_raddr = '0;
      case (st_ff)
         SS_IDLE: begin
            if (sort_start) begin
               if (item_num < IW'(2)) begin
                  sort_done = 1'b1;
               end else begin
                  lo_in = (item_num >> 1) + IW'(1);
                  hi_in = item_num;
                  st_in = SS_OUTER;
               end
            end
         end
         SS_OUTER: begin
            if (lo_ff > IW'(1)) begin
               lo_in     = lo_ff - IW'(1);
               mem_raddr = AW'(lo_ff - IW'(2));
               st_in     = SS_LOAD_HK;
            end else begin
               mem_raddr = hi_m1[AW-1:0];
               st_in     = SS_TAKE_LAST;
            end
         end
         SS_LOAD_HK: begin
            hk_in  = mem_rd_data;
            pos_in = lo_ff;
            kid_in = {lo_ff, 1'b0};
            st_in  = SS_SIFT;
         end
         SS_TAKE_LAST: begin
            hk_in     = mem_rd_data;
            mem_raddr = '0;
            st_in     = SS_ROOT_RD;
         end
         SS_ROOT_RD: begin
            // move the root to the end of the shrinking heap
            mem_we    = 1'b1;
            mem_waddr = hi_m1[AW-1:0];
            mem_wdata = mem_rd_data;
            hi_in     = hi_m1;
            if (hi_m1 == IW'(1)) begin
               st_in = SS_FINAL_WR;
            end else begin
               pos_in = lo_ff;
               kid_in = {lo_ff, 1'b0};
               st_in  = SS_SIFT;
            end
         end
         SS_FINAL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = hk_ff;
            sort_done = 1'b1;
            st_in     = SS_IDLE;
         end
         SS_SIFT: begin
            if (kid_ff <= {1'b0, hi_ff}) begin
               mem_raddr = kid_m1[AW-1:0];
               st_in     = SS_RD_A;
            end else begin
               mem_we = 1'b1;
               st_in  = SS_OUTER;
            end
         end
         SS_RD_A: begin
            if (kid_ff < {1'b0, hi_ff}) begin
               a_in      = mem_rd_data;
               mem_raddr = kid_ff[AW-1:0];
               st_in     = SS_RD_B;
            end else if ($signed(hk_ff[DW-1:TAG_BITS]) <
                         $signed(mem_rd_data[DW-1:TAG_BITS])) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rd_data;
               pos_in    = kid_ff[IW-1:0];
               kid_in    = {kid_ff[IW-1:0], 1'b0};
               st_in     = SS_SIFT;
            end else begin
               mem_we = 1'b1;
               st_in  = SS_OUTER;
            end
         end
         SS_RD_B: begin
            if ($signed(hk_ff[DW-1:TAG_BITS]) < $signed(big_word[DW-1:TAG_BITS])) begin
               mem_we    = 1'b1;
               mem_wdata = big_word;
               pos_in    = big_idx;
               kid_in    = {big_idx, 1'b0};
               st_in     = SS_SIFT;
            end else begin
               mem_we = 1'b1;
               st_in  = SS_OUTER;
            end
         end
         default: begin
            st_in = SS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SS_IDLE;
      end else begin
         st_ff <= st_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      pos_ff <= pos_in;
      kid_ff <= kid_in;
      hk_ff  <= hk_in;
      a_ff   <= a_in;
   end

endmodule : hswt_sorter

`default_nettype wire

@@ sv/heap_sort_with_tags_top.sv @@
// ----------------------------------------------------------------------------
// heap_sort_with_tags_top - collect, heapsort and replay tagged items
//
// Usage:
//  - req_* carries (key, tag) transactions; req_tlast closes a set. One
//    transaction is taken per cycle while the block is collecting.
//  - Up to MAX_ITEMS items are held; further items are dropped and every
//    result of that set carries rsp_tuser = 1 (overflow).
//  - After the closing transaction req_tready drops while the set is sorted
//    in place in a single item memory (one read and one write port, read
//    data registered).
//  - Results leave on rsp_* in ascending key order (memory read, then output
//    register, one read pending at most); rsp_tlast marks the last.
//  - A stalled receiver holds the output register and pauses memory reads.
//    Once the final read is issued the block collects again, so a new set
//    may start loading while the last result still waits to be taken.
//  - Synchronous reset empties the block and drops any result in flight;
//    memory contents are left as they are, as only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_with_tags_top #(
   parameter int MAX_ITEMS = 64,
   parameter int KEY_BITS  = 32,
   parameter int TAG_BITS  = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   // req_tdata: [KEY_BITS-1:0] key, then tag, zero padding to whole bytes
   input  wire logic [((KEY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic                                         req_tlast,
   input  wire logic                                         req_tvalid,
   output logic                                              req_tready,
   // rsp_tdata: [KEY_BITS-1:0] sorted_key, then sorted_tag, zero padding
   output logic [((KEY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0]      rsp_tdata,
   output logic                                              rsp_tlast,
   // rsp_tuser: [0] overflow
   output logic                                              rsp_tuser,
   output logic                                              rsp_tvalid,
   input  wire logic                                         rsp_tready
);
   import hswt_pkg::*;

   localparam int IW    = $clog2(MAX_ITEMS + 1);
   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int DW    = KEY_BITS + TAG_BITS;
   localparam int REQ_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;

   // item memory: {key, tag} per entry
   logic [DW-1:0]  mem [MAX_ITEMS];
   logic [DW-1:0]  rd_data_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [DW-1:0]  mem_wdata;
   logic [AW-1:0]  mem_raddr;

   // sorter port
   logic           srt_done;
   logic           srt_we;
   logic [AW-1:0]  srt_waddr;
   logic [DW-1:0]  srt_wdata;
   logic [AW-1:0]  srt_raddr;

   top_state_type  st_ff, st_in;
   logic [IW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [IW-1:0]  n_ff, n_in;
   logic           set_ovf_ff, set_ovf_in;
   logic           start_ff, start_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic           rd_pend_ff, rd_pend_in;
   logic           rd_last_ff, rd_last_in;
   logic           out_vld_ff, out_vld_in;
   logic [DW-1:0]  out_word_ff, out_word_in;
   logic           out_eos_ff, out_eos_in;
   logic           out_ovf_ff, out_ovf_in;

   logic           req_acc;
   logic           full;
   logic           issue;
   logic [IW-1:0]  cnt_inc;
   logic [IW-1:0]  idx_inc;

   assign req_tready = (st_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign full       = (cnt_ff == IW'(MAX_ITEMS));
   assign cnt_inc    = full ? cnt_ff : (cnt_ff + IW'(1));
   assign idx_inc    = idx_ff + IW'(1);
   // read the next result only when the output register frees up
   assign issue      = (st_ff == ST_EMIT) && !rd_pend_ff && (!out_vld_ff || rsp_tready);

   hswt_sorter #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS),
      .TAG_BITS  (TAG_BITS),
      .IW        (IW),
      .AW        (AW),
      .DW        (DW)
   ) u_sorter (
      .clock       (clock),
      .reset       (reset),
      .sort_start  (start_ff),
      .item_num    (n_ff),
      .sort_done   (srt_done),
      .mem_we      (srt_we),
      .mem_waddr   (srt_waddr),
      .mem_wdata   (srt_wdata),
      .mem_raddr   (srt_raddr),
      .mem_rd_data (rd_data_ff)
   );

   // memory port ownership follows the phase
   always_comb begin
      if (st_ff == ST_SORT) begin
         mem_we    = srt_we;
         mem_waddr = srt_waddr;
         mem_wdata = srt_wdata;
         mem_raddr = srt_raddr;
      end else begin
         mem_we    = req_acc && !full;
         mem_waddr = cnt_ff[AW-1:0];
         mem_wdata = {req_tdata[KEY_BITS-1:0], req_tdata[DW-1:KEY_BITS]};
         mem_raddr = idx_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      st_in       = st_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      n_in        = n_ff;
      set_ovf_in  = set_ovf_ff;
      start_in    = 1'b0;
      idx_in      = idx_ff;
      rd_pend_in  = 1'b0;
      rd_last_in  = rd_last_ff;
      out_vld_in  = out_vld_ff;
      out_word_in = out_word_ff;
      out_eos_in  = out_eos_ff;
      out_ovf_in  = out_ovf_ff;

      case (st_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (req_tlast) begin
                  // close the set: hand the count and overflow to the sort
                  n_in       = cnt_inc;
                  set_ovf_in = ovf_ff || full;
                  cnt_in     = '0;
                  ovf_in     = 1'b0;
                  idx_in     = '0;
                  start_in   = 1'b1;
                  st_in      = ST_SORT;
               end else begin
                  cnt_in = cnt_inc;
                  ovf_in = ovf_ff || full;
               end
            end
         end
         ST_SORT: begin
            if (srt_done) begin
               st_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               idx_in     = idx_inc;
               rd_pend_in = 1'b1;
               rd_last_in = (idx_inc == n_ff);
               if (idx_inc == n_ff) begin
                  st_in = ST_LOAD;
               end
            end
         end
         default: begin
            st_in = ST_LOAD;
         end
      endcase

      // output register: load from the memory, drop on acceptance
      if (rd_pend_ff) begin
         out_vld_in  = 1'b1;
         out_word_in = rd_data_ff;
         out_eos_in  = rd_last_ff;
         out_ovf_in  = set_ovf_ff;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_LOAD;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         start_ff   <= 1'b0;
         rd_pend_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         start_ff   <= start_in;
         rd_pend_ff <= rd_pend_in;
         out_vld_ff <= out_vld_in;
      end
      n_ff        <= n_in;
      set_ovf_ff  <= set_ovf_in;
      idx_ff      <= idx_in;
      rd_last_ff  <= rd_last_in;
      out_word_ff <= out_word_in;
      out_eos_ff  <= out_eos_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = REQ_W'({out_word_ff[TAG_BITS-1:0], out_word_ff[DW-1:TAG_BITS]});
   assign rsp_tlast  = out_eos_ff;
   assign rsp_tuser  = out_ovf_ff;

endmodule : heap_sort_with_tags_top

`default_nettype wire

@@ sv/hswt_checker.sv @@
// ----------------------------------------------------------------------------
// hswt_checker - port-level checks for the tagged heap sorter
// Watches the stream ports over time and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module hswt_checker #(
   parameter int DATA_W = 48
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tlast,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic              rsp_tlast,
   input wire logic              rsp_tuser,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its contents
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // closing a set stops collection for the sort
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still taken after the closing transaction");

   // reset leaves no result on the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // an offered result carries no unknown bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown({rsp_tdata, rsp_tlast, rsp_tuser}))
      else $error("result carries unknown bits");

endmodule : hswt_checker

bind heap_sort_with_tags_top hswt_checker #(
   .DATA_W (REQ_W)
) u_hswt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tlast  (req_tlast),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

@@ sim/heap_sort_with_tags_top_tb.sv @@
// ----------------------------------------------------------------------------
// heap_sort_with_tags_top_tb - self-checking bench for the tagged heap sorter
//
// Streams sets of (key, tag) transactions into the sorter and holds its own
// heapsort of every set. Each set is sorted with the same sift rule as the
// block, so equal keys must come back with their tags in the same order.
// Every result transaction is checked field by field against the oldest
// expected one. The sender runs in bursts with random gaps. The receiver
// stalls on a pattern of its own, and once holds off long enough to back the
// block up to its input. Sets range from a single item to sets that overrun
// the capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heap_sort_with_tags_top_tb;

   localparam int MAX_ITEMS  = 64;
   localparam int KEY_BITS   = 32;
   localparam int TAG_BITS   = 16;
   localparam int DATA_BITS  = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 20000;   // cycles with no transaction at all
   localparam int DRAIN      = 200;     // quiet cycles after the last result
   localparam int LONG_HOLD  = 500;     // the one long receiver hold-off

   // how the keys of a generated set are chosen
   typedef enum int {
      KEY_ANY,
      KEY_FEW,
      KEY_EDGE,
      KEY_RISING,
      KEY_FALLING
   } key_mode_type;

   // receiver behaviour between stalls
   typedef enum int {
      READY_FULL,
      READY_COIN,
      READY_SPARSE
   } ready_mode_type;

   typedef struct {
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0]        tag;
      logic                       last;
   } set_item_type;

   typedef struct {
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_BITS-1:0]        tag;
      logic                       end_of_set;
      logic                       overflow;
   } sorted_item_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;

   // stimulus waiting to be offered, and results the sorter still owes us
   set_item_type    pending_items[$];
   sorted_item_type sorted_due[$];

   // shadow of the sorter's item memory for the set being collected
   logic signed [KEY_BITS-1:0] held_key [MAX_ITEMS];
   logic [TAG_BITS-1:0]        held_tag [MAX_ITEMS];
   int                         held_count    = 0;
   logic                       held_overflow = 1'b0;

   int errors          = 0;
   int items_taken     = 0;
   int results_checked = 0;
   int sets_closed     = 0;
   int overflow_sets   = 0;
   int largest_set     = 0;

   heap_sort_with_tags_top #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS),
      .TAG_BITS  (TAG_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Sorting predictor: store one accepted item; on the closing item, heapsort
   // the held set in place and queue every sorted result.
   // -------------------------------------------------------------------------
   task automatic absorb_item(input set_item_type item);
      int unsigned                lo, hi, pos, kid, n;
      logic signed [KEY_BITS-1:0] hk;
      logic [TAG_BITS-1:0]        ht;
      logic                       done;
      if (held_count < MAX_ITEMS) begin
         held_key[held_count] = item.key;
         held_tag[held_count] = item.tag;
         held_count++;
      end else begin
         // capacity reached: drop the item, flag the whole set
         held_overflow = 1'b1;
      end
      if (item.last) begin
         n = held_count;
         if (n >= 2) begin
            // heap indices are 1-based, as in the textbook formulation
            lo   = (n >> 1) + 1;
            hi   = n;
            done = 1'b0;
            while (!done) begin
               if (lo > 1) begin
                  // heap build: take the next parent downwards
                  lo--;
                  hk = held_key[lo-1];
                  ht = held_tag[lo-1];
               end else begin
                  // extraction: move the root behind the shrinking heap
                  hk = held_key[hi-1];
                  ht = held_tag[hi-1];
                  held_key[hi-1] = held_key[0];
                  held_tag[hi-1] = held_tag[0];
                  hi--;
                  if (hi == 1) begin
                     held_key[0] = hk;
                     held_tag[0] = ht;
                     done = 1'b1;
                  end
               end
               if (!done) begin
                  // sift the hole down, the larger child moving up
                  pos = lo;
                  kid = lo + lo;
                  while (kid <= hi) begin
                     if (kid < hi && held_key[kid-1] < held_key[kid])
                        kid++;
                     if (hk < held_key[kid-1]) begin
                        held_key[pos-1] = held_key[kid-1];
                        held_tag[pos-1] = held_tag[kid-1];
                        pos = kid;
                        kid = kid << 1;
                     end else begin
                        kid = hi + 1;
                     end
                  end
                  held_key[pos-1] = hk;
                  held_tag[pos-1] = ht;
               end
            end
         end
         for (int k = 0; k < n; k++)
            sorted_due.push_back('{held_key[k], held_tag[k], k + 1 == n, held_overflow});
         sets_closed++;
         if (held_overflow)
            overflow_sets++;
         if (n > largest_set)
            largest_set = n;
         held_count    = 0;
         held_overflow = 1'b0;
      end
   endtask

   task automatic push_item(input logic [KEY_BITS-1:0] key, input logic [TAG_BITS-1:0] tag,
                            input logic last);
      pending_items.push_back('{key, tag, last});
   endtask

   // queue one whole set, closing transaction included
   task automatic queue_set(input int size, input key_mode_type mode);
      logic [KEY_BITS-1:0] base, key;
      base = $urandom;
      for (int i = 0; i < size; i++) begin
         case (mode)
            KEY_FEW:     key = $urandom_range(0, 6) - 3;
            KEY_EDGE: begin
               case ($urandom_range(0, 4))
                  0:       key = {1'b1, {(KEY_BITS-1){1'b0}}};
                  1:       key = {1'b0, {(KEY_BITS-1){1'b1}}};
                  2:       key = '1;
                  3:       key = '0;
                  default: key = 1;
               endcase
            end
            KEY_RISING:  key = base + i * $urandom_range(0, 9);
            KEY_FALLING: key = base - i * $urandom_range(0, 9);
            default:     key = $urandom;
         endcase
         push_item(key, TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1)), i == size - 1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Driver: offer queued transactions in bursts, hold each until taken, and
   // feed the predictor at the edge where the handshake completes.
   // -------------------------------------------------------------------------
   set_item_type offered;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_item(offered);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               offered = pending_items.pop_front();
               req_tdata  <= {offered.tag, offered.key};
               req_tlast  <= offered.last;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  // new burst; a third of them follow on with no pause at all
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall on a changing pattern, and once hold off for a long
   // stretch while results are waiting, so the block backs up to its input.
   // -------------------------------------------------------------------------
   ready_mode_type ready_mode   = READY_FULL;
   int             mode_left    = 0;
   int             hold_left    = 0;
   logic           hold_done    = 1'b0;
   int             results_seen = 0;

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         results_seen++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_tvalid && results_seen >= 60) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(READY_FULL, READY_SPARSE));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= 1'b1;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: compare every result transaction with the oldest expectation.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      sorted_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_due.size() == 0) begin
            $error("result with nothing expected: key %0d tag %0d",
                   $signed(rsp_tdata[KEY_BITS-1:0]), rsp_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]);
            errors++;
         end else begin
            want = sorted_due.pop_front();
            results_checked++;
            if (rsp_tdata[KEY_BITS-1:0] !== want.key) begin
               $error("sorted_key mismatch: expected %0d, got %0d",
                      want.key, $signed(rsp_tdata[KEY_BITS-1:0]));
               errors++;
            end
            if (rsp_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS] !== want.tag) begin
               $error("sorted_tag mismatch: expected %0d, got %0d",
                      want.tag, rsp_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]);
               errors++;
            end
            if (rsp_tlast !== want.end_of_set) begin
               $error("end_of_set mismatch: expected %0b, got %0b", want.end_of_set, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow mismatch: expected %0b, got %0b", want.overflow, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long. The long
   // hold-off is shorter than that limit.
   // -------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, sorted_due.size());
         $display("heap_sort_with_tags_top test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      int total_items;
      int pick;
      // single-item sets at both key extremes
      push_item({1'b1, {(KEY_BITS-1){1'b0}}}, '1, 1'b1);
      push_item({1'b0, {(KEY_BITS-1){1'b1}}}, '0, 1'b1);
      // extremes with repeats: min, max, -1, 0, 1, max, min
      push_item({1'b1, {(KEY_BITS-1){1'b0}}}, 16'd1, 1'b0);
      push_item({1'b0, {(KEY_BITS-1){1'b1}}}, 16'd2, 1'b0);
      push_item('1, 16'd3, 1'b0);
      push_item('0, 16'd4, 1'b0);
      push_item(1, 16'd5, 1'b0);
      push_item({1'b0, {(KEY_BITS-1){1'b1}}}, 16'hAAAA, 1'b0);
      push_item({1'b1, {(KEY_BITS-1){1'b0}}}, 16'h5555, 1'b1);
      // all keys equal: tag order follows the sift rule alone
      for (int i = 0; i < 6; i++)
         push_item(5, TAG_BITS'(16'h00F0 + i), i == 5);
      queue_set(5, KEY_FALLING);
      queue_set(4, KEY_RISING);

      // a full set, an overrun whose closing item is dropped, a longer overrun
      queue_set(MAX_ITEMS, KEY_ANY);
      queue_set(MAX_ITEMS + 1, KEY_FEW);
      queue_set(MAX_ITEMS + 3, KEY_ANY);
      while (pending_items.size() < 500) begin
         pick = $urandom_range(0, 99);
         queue_set(pick < 75 ? $urandom_range(1, 12) :
                   pick < 90 ? $urandom_range(13, 40) :
                   pick < 95 ? MAX_ITEMS : $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 3),
                   key_mode_type'($urandom_range(KEY_ANY, KEY_FALLING)));
      end
      total_items = pending_items.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // sample at the falling edge, clear of the clocked processes
      while (items_taken < total_items)
         @(negedge clock);
      while (sorted_due.size() > 0)
         @(negedge clock);
      // stay a while so that any stray result still shows up
      repeat (DRAIN) @(posedge clock);

      $display("Sorted %0d sets (%0d overrun, largest %0d held) from %0d items;",
               sets_closed, overflow_sets, largest_set, total_items);
      $display("checked %0d results under bursty input and a stalling receiver.",
               results_checked);
      if (errors == 0)
         $display("heap_sort_with_tags_top test passed");
      else
         $display("heap_sort_with_tags_top test failed");
      $finish;
   end

endmodule
